>>> hw/rtl/slf_pkg.sv
// Shared types and constants for the serial line framer.
// No dependencies; every other file of the block imports this package.
package slf_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_SPLIT_MODE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_LINE_LENGTH  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TERM_LENGTH  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TERM_BYTES   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PAUSED       = 3'd5;

	localparam logic [1:0] SPLIT_LENGTH = 2'd0;
	localparam logic [1:0] SPLIT_TERM   = 2'd1;
	localparam logic [1:0] SPLIT_NEVER  = 2'd2;

	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_LENGTH  = 2'd1;
	localparam logic [1:0] CAUSE_TERM    = 2'd2;
	localparam logic [1:0] CAUSE_TIMEOUT = 2'd3;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [1:0]  RST_SPLIT_MODE   = SPLIT_TERM;
	localparam logic [15:0] RST_LINE_LENGTH  = 16'd16;
	localparam logic [2:0]  RST_TERM_LENGTH  = 3'd1;
	localparam logic [31:0] RST_TERM_BYTES   = 32'h0000_000A;
	localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd300;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Queue between the front and the back.
	localparam int QDepth = 2;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCw    = $clog2(QDepth + 1);

	// Class of a queued beat, decided at the front.
	typedef enum logic [1:0] {
		CLS_BYTE = 2'd0,
		CLS_DROP = 2'd1,
		CLS_TICK = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] data;
	} qent_t;

	typedef struct packed {
		logic [1:0]  split_mode;
		logic [15:0] line_length;
		logic [2:0]  term_len;
		logic [31:0] term_bytes;
		logic [15:0] idle_timeout;
		logic        paused;
	} cfg_t;

	typedef struct packed {
		logic       is_flush;
		logic [7:0] out_byte;
		logic       line_end;
		logic [1:0] end_cause;
	} result_t;

endpackage

>>> hw/rtl/slf_channels.sv
// Handshake channels of the serial line framer: input items, results and
// configuration writes. Depends on slf_pkg for the configuration widths.
interface slf_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, mode, rx_byte, input ready);
	modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface slf_out_if;
	logic       valid;
	logic       ready;
	logic       is_flush;
	logic [7:0] out_byte;
	logic       line_end;
	logic [1:0] end_cause;

	modport source (output valid, is_flush, out_byte, line_end, end_cause, input ready);
	modport sink (input valid, is_flush, out_byte, line_end, end_cause, output ready);
endinterface

interface slf_cfg_if import slf_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/slf_front.sv
// Front of the framer: holds the configuration registers and classifies
// each accepted beat for the queue. Depends on slf_pkg and slf_channels.
module slf_front import slf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	slf_in_if.sink        items,
	slf_cfg_if.sink       cfg,
	input  logic          q_full,
	output logic          push,
	output qent_t         push_data,
	output cfg_t          cfg_out
);

	cfg_t cfg_q;

	assign cfg.ready   = 1'b1;
	assign items.ready = !q_full;
	assign push        = items.valid && !q_full;
	assign cfg_out     = cfg_q;

	always_comb begin
		push_data.data = items.rx_byte;
		if (items.mode == MODE_TICK) begin
			push_data.cls = CLS_TICK;
		end else if (cfg_q.paused) begin
			push_data.cls = CLS_DROP;
		end else begin
			push_data.cls = CLS_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.split_mode   <= RST_SPLIT_MODE;
			cfg_q.line_length  <= RST_LINE_LENGTH;
			cfg_q.term_len     <= RST_TERM_LENGTH;
			cfg_q.term_bytes   <= RST_TERM_BYTES;
			cfg_q.idle_timeout <= RST_IDLE_TIMEOUT;
			cfg_q.paused       <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SPLIT_MODE:   cfg_q.split_mode   <= cfg.data[1:0];
				REG_LINE_LENGTH:  cfg_q.line_length  <= cfg.data[15:0];
				REG_TERM_LENGTH:  cfg_q.term_len     <= cfg.data[2:0];
				REG_TERM_BYTES:   cfg_q.term_bytes   <= cfg.data[31:0];
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg.data[15:0];
				REG_PAUSED:       cfg_q.paused       <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/slf_queue.sv
// Two-entry queue of classified beats between the front and the back.
// Depends on slf_pkg for the entry type and depth.
module slf_queue import slf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output qent_t head_data
);

	qent_t            mem_q [QDepth];
	logic [QAw-1:0]   wr_ptr_q;
	logic [QAw-1:0]   rd_ptr_q;
	logic [QCw-1:0]   count_q;
	logic             do_pop;

	assign full       = (count_q == QCw'(QDepth));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCw'(QDepth))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> full)
		else $error("queue left full state without a pop");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> head_valid)
		else $error("pushed beat not visible at head");
`endif

endmodule

>>> hw/rtl/slf_back.sv
// Back of the framer: line state, end-of-line detection, idle timer and
// the output register. Depends on slf_pkg and slf_channels.
module slf_back import slf_pkg::*; #(
	parameter int MAX_TERM_BYTES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      head_valid,
	input  qent_t     head_data,
	output logic      pop,
	slf_out_if.source results
);

	localparam int RW = 8 * MAX_TERM_BYTES;

	logic [15:0]   line_count_q;
	logic [RW-1:0] recent_q;
	logic [15:0]   idle_ticks_q;
	logic          armed_q;
	logic          out_valid_q;
	result_t       out_q;

	logic [15:0]   count_inc;
	logic [15:0]   idle_inc;
	logic [RW+7:0] recent_cat;
	logic [RW-1:0] recent_next;
	logic [RW-1:0] term_ext;
	logic [3:0]    term_n;
	logic          term_hit;
	logic [1:0]    cause;
	logic          close_line;
	logic          res_valid;
	result_t       res;
	logic [15:0]   nxt_count;
	logic [RW-1:0] nxt_recent;
	logic [15:0]   nxt_idle;
	logic          nxt_armed;

	assign pop = head_valid && (!out_valid_q || results.ready);

	assign results.valid     = out_valid_q;
	assign results.is_flush  = out_q.is_flush;
	assign results.out_byte  = out_q.out_byte;
	assign results.line_end  = out_q.line_end;
	assign results.end_cause = out_q.end_cause;

	always_comb begin
		count_inc   = (line_count_q == COUNT_MAX) ? line_count_q : line_count_q + 16'd1;
		idle_inc    = (idle_ticks_q == COUNT_MAX) ? idle_ticks_q : idle_ticks_q + 16'd1;
		recent_cat  = {recent_q, head_data.data};
		recent_next = recent_cat[RW-1:0];
		term_ext    = RW'(cfg.term_bytes);
		// Terminator lengths above the supported byte count are clamped.
		if (4'(cfg.term_len) > 4'(MAX_TERM_BYTES)) begin
			term_n = 4'(MAX_TERM_BYTES);
		end else begin
			term_n = 4'(cfg.term_len);
		end
		term_hit = 1'b1;
		for (int k = 0; k < MAX_TERM_BYTES; k++) begin
			if (4'(k) < term_n && recent_next[8*k +: 8] != term_ext[8*k +: 8]) begin
				term_hit = 1'b0;
			end
		end
		case (cfg.split_mode)
			SPLIT_LENGTH: cause = (count_inc >= cfg.line_length) ? CAUSE_LENGTH : CAUSE_NONE;
			SPLIT_TERM:   cause = (term_hit && count_inc >= 16'(term_n)) ? CAUSE_TERM
			                                                             : CAUSE_NONE;
			default:      cause = CAUSE_NONE;
		endcase
	end

	always_comb begin
		nxt_count     = line_count_q;
		nxt_recent    = recent_q;
		nxt_idle      = idle_ticks_q;
		nxt_armed     = armed_q;
		close_line    = 1'b0;
		res_valid     = 1'b0;
		res.is_flush  = 1'b0;
		res.out_byte  = head_data.data;
		res.line_end  = 1'b0;
		res.end_cause = CAUSE_NONE;
		case (head_data.cls)
			CLS_TICK: begin
				if (armed_q && line_count_q != '0) begin
					if (idle_inc < cfg.idle_timeout) begin
						nxt_idle = idle_inc;
					end else begin
						close_line    = 1'b1;
						res_valid     = 1'b1;
						res.is_flush  = 1'b1;
						res.out_byte  = 8'd0;
						res.line_end  = 1'b1;
						res.end_cause = CAUSE_TIMEOUT;
					end
				end
			end
			CLS_DROP: begin
				// A dropped byte still stops the idle timer.
				nxt_idle  = '0;
				nxt_armed = 1'b0;
			end
			CLS_BYTE: begin
				res_valid     = 1'b1;
				res.end_cause = cause;
				res.line_end  = (cause != CAUSE_NONE);
				nxt_idle      = '0;
				if (cause != CAUSE_NONE) begin
					close_line = 1'b1;
				end else begin
					nxt_count  = count_inc;
					nxt_recent = recent_next;
					nxt_armed  = 1'b1;
				end
			end
			default: ;
		endcase
		if (close_line) begin
			nxt_count  = '0;
			nxt_recent = '0;
			nxt_idle   = '0;
			nxt_armed  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			recent_q     <= '0;
			idle_ticks_q <= '0;
			armed_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (pop) begin
			line_count_q <= nxt_count;
			recent_q     <= nxt_recent;
			idle_ticks_q <= nxt_idle;
			armed_q      <= nxt_armed;
			out_valid_q  <= res_valid;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && close_line |=> line_count_q == '0 && !armed_q)
		else $error("line state not cleared after line end");
	a_armed_pending: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> line_count_q != '0)
		else $error("idle timer running with no pending line");
	a_empty_line: assert property (@(posedge clk) disable iff (!arst_n)
		line_count_q == '0 |-> recent_q == '0 && idle_ticks_q == '0)
		else $error("stale history with an empty line");
	a_flush_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_flush |->
			out_q.line_end && out_q.end_cause == CAUSE_TIMEOUT && out_q.out_byte == 8'd0)
		else $error("malformed flush marker");
`endif

endmodule

>>> hw/rtl/serial_line_framer_top.sv
// Top level of the serial line framer: front, queue and back.
// Depends on slf_pkg, slf_channels, slf_front, slf_queue and slf_back.
//
// Usage: received bytes and idle ticks enter on the items channel (mode 0
// is a byte, mode 1 a tick). Each unpaused byte leaves on the results
// channel as an echo beat, flagged with line_end and end_cause when it
// closes the line by length or terminator. A tick that reaches the idle
// timeout with a partial line pending yields a flush marker beat; other
// ticks and paused bytes produce no result. Registers are written on the
// cfg channel, which is always ready; write them only while the block is
// idle.
// Throughput is one item per cycle while the results receiver keeps up. A
// result passes through the two-entry queue and then the output register.
// When the results receiver stalls, the output register holds its beat,
// the queue fills, and items.ready drops once it is full.
// Reset restores the register defaults and clears the line state and the
// queue; no clearing pass is needed.
module serial_line_framer_top import slf_pkg::*; #(
	parameter int MAX_TERM_BYTES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	slf_in_if.sink    items,
	slf_out_if.source results,
	slf_cfg_if.sink   cfg
);

	logic  q_full;
	logic  push;
	qent_t push_data;
	cfg_t  cfg_cur;
	logic  pop;
	logic  head_valid;
	qent_t head_data;

	slf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data),
		.cfg_out   (cfg_cur)
	);

	slf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	slf_back #(
		.MAX_TERM_BYTES (MAX_TERM_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_cur),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.results    (results)
	);

endmodule
